FILE: src/kaeq_pkg.sv
package kaeq_pkg;

  // defaults for the top-level parameters
  localparam int NUM_CONN_DEF  = 64;
  localparam int TIME_BITS_DEF = 32;

  // fixed field widths
  localparam int CFG_W      = 16;
  localparam int ID_W       = 6;
  localparam int QUEUED_W   = 7;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;

  localparam logic [CFG_W-1:0] TIMEOUT_RST = 16'd15;

  // input item kind
  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_ACT  = 2'd1,
    MODE_HANG = 2'd2,
    MODE_RSVD = 2'd3
  } kaeq_mode_t;

  // result action
  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_EXPIRE    = 2'd1,
    ACT_REQ_CLOSE = 2'd2,
    ACT_HANGUP    = 2'd3
  } kaeq_action_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OP,
    ST_HEAD,
    ST_RING,
    ST_DL,
    ST_END
  } kaeq_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;    // take the input word, advance time on a tick
    logic ring_rd;   // read ring entry at head
    logic dl_rd;     // read deadline of the head connection
    logic pop;       // pop head, hold its result, flush older held result
    logic end_emit;  // give the final result of a tick
    logic op_emit;   // update state for activity or hangup and give result
  } kaeq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_tick;
    logic ring_empty;
    logic expired;
    logic pend_vld;
    logic out_free;
  } kaeq_stat_t;

endpackage

FILE: src/kaeq_ctrl.sv
module kaeq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  kaeq_pkg::kaeq_stat_t stat,
  output kaeq_pkg::kaeq_cmd_t  cmd
);
  import kaeq_pkg::*;

  kaeq_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = stat.in_tick ? ST_HEAD : ST_OP;
        end
      end
      ST_OP: begin
        if (stat.out_free) begin
          cmd.op_emit = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      // walk the ring heads while they are expired
      ST_HEAD: begin
        if (stat.ring_empty) begin
          state_nxt = ST_END;
        end else begin
          cmd.ring_rd = 1'b1;
          state_nxt   = ST_RING;
        end
      end
      ST_RING: begin
        cmd.dl_rd = 1'b1;
        state_nxt = ST_DL;
      end
      ST_DL: begin
        if (!stat.expired) begin
          state_nxt = ST_END;
        end else if (!stat.pend_vld || stat.out_free) begin
          cmd.pop   = 1'b1;
          state_nxt = ST_HEAD;
        end
      end
      ST_END: begin
        if (stat.out_free) begin
          cmd.end_emit = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: src/kaeq_dp.sv
module kaeq_dp #(
  parameter int NUM_CONN  = kaeq_pkg::NUM_CONN_DEF,
  parameter int TIME_BITS = kaeq_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [kaeq_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [1:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [kaeq_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [1:0]                        out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [kaeq_pkg::CFG_W-1:0]        cfg_wdata,
  input  kaeq_pkg::kaeq_cmd_t               cmd,
  output kaeq_pkg::kaeq_stat_t              stat
);
  import kaeq_pkg::*;

  localparam int IDX_W = $clog2(NUM_CONN);
  localparam int CNT_W = $clog2(NUM_CONN + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_CONN - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_CONN);

  // memories
  logic [TIME_BITS-1:0] dl_mem   [NUM_CONN];
  logic [IDX_W-1:0]     ring_mem [NUM_CONN];

  logic [CFG_W-1:0]     timeout_r;
  logic [TIME_BITS-1:0] now_r;
  logic [NUM_CONN-1:0]  alive_r, alive_nxt;
  logic [IDX_W-1:0]     head_r, head_nxt;
  logic [IDX_W-1:0]     tail_r, tail_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;

  kaeq_mode_t           in_mode_r;
  logic [ID_W-1:0]      in_id_r;
  logic                 in_ka_r;

  logic [IDX_W-1:0]     ring_q;
  logic [TIME_BITS-1:0] dl_q;

  logic                 pend_vld_r;
  logic [IDX_W-1:0]     pend_id_r;
  logic [CNT_W-1:0]     pend_queued_r;

  logic                 out_valid_r;
  kaeq_action_t         out_act_r;
  logic [ID_W-1:0]      out_id_r;
  logic                 out_full_r;
  logic [QUEUED_W-1:0]  out_queued_r;
  logic                 out_last_r;

  // activity / hangup decode
  logic                 in_range;
  logic [IDX_W-1:0]     id_idx;
  logic                 alive_cur;
  kaeq_action_t         op_act;
  logic                 op_show_id;
  logic                 op_full;
  logic                 op_push;
  logic                 op_set;
  logic                 op_clr;
  logic                 dl_we;
  logic [TIME_BITS-1:0] dl_wdata;

  // emit path
  logic                 emit;
  kaeq_action_t         e_act;
  logic [ID_W-1:0]      e_id;
  logic                 e_full;
  logic [QUEUED_W-1:0]  e_queued;
  logic                 e_last;

  assign in_range  = {1'b0, in_id_r} < 7'(NUM_CONN);
  assign id_idx    = in_id_r[IDX_W-1:0];
  assign alive_cur = in_range && alive_r[id_idx];

  always_comb begin
    op_act     = ACT_NONE;
    op_show_id = 1'b0;
    op_full    = 1'b0;
    op_push    = 1'b0;
    op_set     = 1'b0;
    op_clr     = 1'b0;
    dl_we      = 1'b0;
    dl_wdata   = '0;
    unique case (in_mode_r)
      MODE_ACT: begin
        if (in_range) begin
          // a dead connection starts from a cleared record
          dl_we    = in_ka_r || !alive_cur;
          dl_wdata = in_ka_r ? now_r + TIME_BITS'(timeout_r) : '0;
          if (in_ka_r) begin
            if (!alive_cur) begin
              if (count_r == CNT_FULL) begin
                op_act     = ACT_REQ_CLOSE;
                op_show_id = 1'b1;
                op_full    = 1'b1;
              end else begin
                op_push = 1'b1;
                op_set  = 1'b1;
              end
            end
          end else begin
            op_clr     = 1'b1;
            op_act     = ACT_REQ_CLOSE;
            op_show_id = 1'b1;
          end
        end
      end
      MODE_HANG: begin
        if (in_range) begin
          op_clr     = 1'b1;
          op_act     = ACT_HANGUP;
          op_show_id = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ring pointers, count and alive flags
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    alive_nxt = alive_r;
    if (cmd.pop) begin
      head_nxt          = (head_r == IDX_LAST) ? '0 : head_r + 1'b1;
      count_nxt         = count_r - 1'b1;
      alive_nxt[ring_q] = 1'b0;
    end
    if (cmd.op_emit) begin
      if (op_push) begin
        tail_nxt  = (tail_r == IDX_LAST) ? '0 : tail_r + 1'b1;
        count_nxt = count_r + 1'b1;
      end
      if (op_set) alive_nxt[id_idx] = 1'b1;
      if (op_clr) alive_nxt[id_idx] = 1'b0;
    end
  end

  // result selection
  always_comb begin
    emit     = 1'b0;
    e_act    = ACT_NONE;
    e_id     = '0;
    e_full   = 1'b0;
    e_queued = '0;
    e_last   = 1'b0;
    priority if (cmd.pop) begin
      // a further expiry follows, so the held one is not last
      emit     = pend_vld_r;
      e_act    = ACT_EXPIRE;
      e_id     = ID_W'(pend_id_r);
      e_queued = QUEUED_W'(pend_queued_r);
    end else if (cmd.end_emit) begin
      emit   = 1'b1;
      e_last = 1'b1;
      if (pend_vld_r) begin
        e_act    = ACT_EXPIRE;
        e_id     = ID_W'(pend_id_r);
        e_queued = QUEUED_W'(pend_queued_r);
      end else begin
        e_queued = QUEUED_W'(count_r);
      end
    end else if (cmd.op_emit) begin
      emit     = 1'b1;
      e_last   = 1'b1;
      e_act    = op_act;
      e_id     = op_show_id ? in_id_r : '0;
      e_full   = op_full;
      e_queued = QUEUED_W'(count_nxt);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RST;
      now_r       <= '0;
      alive_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) timeout_r <= cfg_wdata;
      if (cmd.accept && kaeq_mode_t'(in_tuser) == MODE_TICK) now_r <= now_r + 1'b1;
      alive_r <= alive_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      if (cmd.pop) begin
        pend_vld_r <= 1'b1;
      end else if (cmd.end_emit) begin
        pend_vld_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_mode_r <= kaeq_mode_t'(in_tuser);
      in_id_r   <= in_tdata[ID_W-1:0];
      in_ka_r   <= in_tdata[ID_W];
    end
    if (cmd.pop) begin
      pend_id_r     <= ring_q;
      pend_queued_r <= count_r - 1'b1;
    end
    if (emit) begin
      out_act_r    <= e_act;
      out_id_r     <= e_id;
      out_full_r   <= e_full;
      out_queued_r <= e_queued;
      out_last_r   <= e_last;
    end
  end

  // ring memory
  always_ff @(posedge clk) begin
    if (cmd.op_emit && op_push) ring_mem[tail_r] <= id_idx;
    if (cmd.ring_rd) ring_q <= ring_mem[head_r];
  end

  // deadline memory
  always_ff @(posedge clk) begin
    if (cmd.op_emit && dl_we) dl_mem[id_idx] <= dl_wdata;
    if (cmd.dl_rd) dl_q <= dl_mem[ring_q];
  end

  // status
  assign stat.in_tick    = kaeq_mode_t'(in_tuser) == MODE_TICK;
  assign stat.ring_empty = count_r == '0;
  assign stat.expired    = dl_q <= now_r;
  assign stat.pend_vld   = pend_vld_r;
  assign stat.out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_act_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_queued_r, out_full_r, out_id_r};

endmodule

FILE: src/keepalive_expiry_queue.sv
// Keep-alive expiry queue: tracks a deadline and an alive flag per connection and a ring of
// connection ids in the order they became alive. An input word is a tick (in_tuser 0), activity
// (1) or a hangup (2); each gives one or more result words, the final one flagged by out_tlast.
// Activity, hangup and unused kinds give their single result from the op state. A tick checks
// the ring heads in turn; for each head the ring memory read and the deadline memory read, both
// registered, are done one after the other, and an expired head is popped. Results sit in an
// output register, and the block waits for it to drain before it places the next result.
// idle_timeout is written through cfg_we / cfg_wdata and resets to 15 ticks.
module keepalive_expiry_queue #(
  parameter int NUM_CONN  = kaeq_pkg::NUM_CONN_DEF,
  parameter int TIME_BITS = kaeq_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [kaeq_pkg::IN_DATA_W-1:0]  in_tdata,   // conn_id[5:0], keep_alive[6], zero
  input  logic [1:0]                      in_tuser,   // mode[1:0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [kaeq_pkg::OUT_DATA_W-1:0] out_tdata,  // closed_id[5:0], queue_full[6],
                                                      // queued[13:7], zero
  output logic [1:0]                      out_tuser,  // action[1:0]
  output logic                            out_tlast,  // last
  input  logic                            cfg_we,
  input  logic [kaeq_pkg::CFG_W-1:0]      cfg_wdata   // idle_timeout
);
  import kaeq_pkg::*;

  kaeq_cmd_t  cmd;
  kaeq_stat_t stat;

  kaeq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  kaeq_dp #(
    .NUM_CONN  (NUM_CONN),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import kaeq_pkg::*;

  localparam int IDLE_LIMIT = 400;

  // one result word as seen on the output side
  typedef struct packed {
    kaeq_action_t action;
    logic [5:0]   closed_id;
    logic         queue_full;
    logic [6:0]   queued;
    logic         last;
  } conn_result_t;

  // connection table and expiry ring mirror, plus the results still owed
  class conn_scoreboard;
    logic [31:0]  deadline [64];
    bit           alive [64];
    logic [5:0]   ring [64];
    logic [5:0]   head;
    logic [5:0]   tail;
    logic [6:0]   count;
    logic [31:0]  now_ticks;
    logic [15:0]  idle_timeout;
    conn_result_t results_due [$];
    int           errors;

    function new();
      foreach (deadline[i]) begin
        deadline[i] = '0;
        alive[i] = 1'b0;
        ring[i] = '0;
      end
      head = '0;
      tail = '0;
      count = '0;
      now_ticks = '0;
      idle_timeout = TIMEOUT_RST;
      errors = 0;
    endfunction

    function void add_result(kaeq_action_t action, logic [5:0] id, logic full);
      conn_result_t r;
      r.action = action;
      r.closed_id = id;
      r.queue_full = full;
      r.queued = count;
      r.last = 1'b0;
      results_due.push_back(r);
    endfunction

    // work out the results of one accepted input word
    function void take_word(kaeq_mode_t mode, logic [5:0] id, logic ka);
      int first;
      logic [5:0] c;
      conn_result_t r;
      first = results_due.size();
      case (mode)
        MODE_TICK: begin
          now_ticks = now_ticks + 32'd1;
          // pop every expired head, stale or not
          while (count != 0) begin
            c = ring[head];
            if (deadline[c] > now_ticks) break;
            head = head + 6'd1;
            count = count - 7'd1;
            alive[c] = 1'b0;
            add_result(ACT_EXPIRE, c, 1'b0);
          end
          if (results_due.size() == first) add_result(ACT_NONE, '0, 1'b0);
        end
        MODE_ACT: begin
          if (!alive[id]) deadline[id] = '0;
          if (ka) begin
            deadline[id] = now_ticks + {16'd0, idle_timeout};
            if (alive[id]) begin
              add_result(ACT_NONE, '0, 1'b0);
            end else if (count >= 7'd64) begin
              // ring full, push dropped
              add_result(ACT_REQ_CLOSE, id, 1'b1);
            end else begin
              ring[tail] = id;
              tail = tail + 6'd1;
              count = count + 7'd1;
              alive[id] = 1'b1;
              add_result(ACT_NONE, '0, 1'b0);
            end
          end else begin
            alive[id] = 1'b0;
            add_result(ACT_REQ_CLOSE, id, 1'b0);
          end
        end
        MODE_HANG: begin
          alive[id] = 1'b0;
          add_result(ACT_HANGUP, id, 1'b0);
        end
        default: add_result(ACT_NONE, '0, 1'b0);
      endcase
      r = results_due.pop_back();
      r.last = 1'b1;
      results_due.push_back(r);
    endfunction

    // compare one accepted result word with the oldest one owed
    function void match_word(conn_result_t got);
      conn_result_t want;
      if (results_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result word: action %0d id %0d full %0d queued %0d last %0d",
                   got.action, got.closed_id, got.queue_full, got.queued, got.last);
        return;
      end
      want = results_due.pop_front();
      if (got.action !== want.action || got.closed_id !== want.closed_id ||
          got.queue_full !== want.queue_full || got.queued !== want.queued ||
          got.last !== want.last) begin
        errors++;
        if (errors <= 10) begin
          $write("result word mismatch: want act %0d id %0d full %0d queued %0d last %0d, ",
                 want.action, want.closed_id, want.queue_full, want.queued, want.last);
          $display("got act %0d id %0d full %0d queued %0d last %0d",
                   got.action, got.closed_id, got.queue_full, got.queued, got.last);
        end
      end
    endfunction

    function int pending();
      return results_due.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  conn_scoreboard sb = new();
  int burst_left = 0;
  int rx_cyc = 0;
  int idle_cycles = 0;

  keepalive_expiry_queue DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // send one word, then maybe open a gap when the burst runs out
  task automatic send_word(kaeq_mode_t mode, logic [5:0] id, logic ka);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {1'b0, ka, id};
    do @(posedge clk); while (!in_tready);
    sb.take_word(mode, id, ka);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if ($urandom_range(4) == 0) begin
        gap = 0;
        burst_left = $urandom_range(60, 30);
      end else begin
        gap = $urandom_range(6);
        burst_left = $urandom_range(10);
      end
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // write idle_timeout once the block has drained
  task automatic set_timeout(logic [15:0] value);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.idle_timeout = value;
    @(posedge clk);
  endtask

  // random mix of ticks, activity and hangups around a pool of ids
  task automatic run_mixed(int items);
    logic [5:0] pool;
    logic [5:0] id;
    int pick;
    pool = 6'($urandom_range(63));
    repeat (items) begin
      pick = $urandom_range(99);
      id = $urandom_range(1) ? 6'($urandom_range(63)) : 6'(pool + $urandom_range(7));
      if (pick < 35)      send_word(MODE_TICK, id, 1'($urandom_range(1)));
      else if (pick < 75) send_word(MODE_ACT, id, 1'b1);
      else if (pick < 83) send_word(MODE_ACT, id, 1'b0);
      else if (pick < 93) send_word(MODE_HANG, id, 1'($urandom_range(1)));
      else                send_word(MODE_RSVD, id, 1'($urandom_range(1)));
    end
  endtask

  // make every connection alive so the ring fills, then hit the full ring
  task automatic run_fill(int extra);
    logic [5:0] start;
    logic [5:0] id;
    int pick;
    start = 6'($urandom_range(63));
    for (int i = 0; i < 64; i++) send_word(MODE_ACT, 6'(start + i), 1'b1);
    repeat (extra) begin
      pick = $urandom_range(9);
      id = 6'($urandom_range(63));
      if (pick < 5)      send_word(MODE_HANG, id, 1'($urandom_range(1)));
      else if (pick < 9) send_word(MODE_ACT, id, 1'b1);
      else               send_word(MODE_TICK, id, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty tick, unused kind, dead hangup, renew, close, stale entries
    send_word(MODE_TICK, 6'd0, 1'b0);
    send_word(MODE_RSVD, 6'd63, 1'b1);
    send_word(MODE_HANG, 6'd63, 1'b1);
    send_word(MODE_ACT, 6'd0, 1'b1);
    send_word(MODE_ACT, 6'd63, 1'b1);
    send_word(MODE_ACT, 6'd0, 1'b1);
    send_word(MODE_ACT, 6'd63, 1'b0);
    send_word(MODE_HANG, 6'd0, 1'b0);
    send_word(MODE_ACT, 6'd0, 1'b1);
    send_word(MODE_ACT, 6'd42, 1'b1);
    send_word(MODE_ACT, 6'd21, 1'b1);
    // run up to the reset timeout so everything expires in one tick
    repeat (15) send_word(MODE_TICK, 6'($urandom_range(63)), 1'($urandom_range(1)));

    set_timeout(16'd1);
    run_mixed(60);
    set_timeout(16'($urandom_range(12, 2)));
    run_mixed(60);
    set_timeout(16'($urandom_range(60, 20)));
    run_mixed(30);
    set_timeout(16'hFFFF);
    run_fill(24);

    // drain and let the block settle
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

  // result side: check accepted words, stall on a rotating pattern
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.match_word({kaeq_action_t'(out_tuser), out_tdata[5:0], out_tdata[6],
                     out_tdata[13:7], out_tlast});
    rx_cyc <= rx_cyc + 1;
    case ((rx_cyc / 300) % 3)
      0: out_tready <= 1'b1;
      1: out_tready <= (rx_cyc % 5) < 3;
      default: out_tready <= 1'($urandom_range(1));
    endcase
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

endmodule

FILE: sim.f
src/kaeq_pkg.sv
src/kaeq_ctrl.sv
src/kaeq_dp.sv
src/keepalive_expiry_queue.sv
sim/tb_top.sv
